// ===== src/b64ld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package b64ld_pkg;

    // Character codes that the decoder treats specially.
    localparam logic [7:0] CH_DASH    = 8'h2D;  // '-'
    localparam logic [7:0] CH_UNDER   = 8'h5F;  // '_'
    localparam logic [7:0] CH_DOT     = 8'h2E;  // '.'
    localparam logic [7:0] CH_PLUS    = 8'h2B;  // '+'
    localparam logic [7:0] CH_SLASH   = 8'h2F;  // '/'
    localparam logic [7:0] CH_PAD     = 8'h3D;  // '='
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;
    localparam logic [7:0] LOWER_BASE   = 8'd26;
    localparam logic [7:0] DIGIT_BASE   = 8'd52;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [7:0] text_char;
        logic       message_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       run_last;
        logic       message_end;
        logic       decode_stopped;
    } t_out_item;

    // Decoder state carried from one character to the next.
    typedef struct packed {
        logic [5:0] first_sextet;
        logic [5:0] second_sextet;
        logic [5:0] third_sextet;
        logic       third_was_pad;
        logic [1:0] group_position;
        logic       stopped_flag;
    } t_state;

    // All results caused by one character, in delivery order from entry 0.
    typedef struct packed {
        t_out_item [MAX_RESULTS-1:0] res;
        logic [1:0]                  count;
    } t_bundle;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

    // URL-safe and dot spellings fold onto the standard alphabet.
    function automatic logic [7:0] normalize_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_DASH) begin
            r = CH_PLUS;
        end else if (c == CH_UNDER) begin
            r = CH_SLASH;
        end else if (c == CH_DOT) begin
            r = CH_PAD;
        end
        return r;
    endfunction

    function automatic t_sextet lookup_sextet(input logic [7:0] c);
        t_sextet    s;
        logic [7:0] t;
        s = '0;
        t = '0;
        if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            t = c - CH_UPPER_A;
            s = '{valid: 1'b1, value: t[5:0]};
        end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            t = c - CH_LOWER_A + LOWER_BASE;
            s = '{valid: 1'b1, value: t[5:0]};
        end else if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
            t = c - CH_DIGIT_0 + DIGIT_BASE;
            s = '{valid: 1'b1, value: t[5:0]};
        end else if (c == CH_PLUS) begin
            s = '{valid: 1'b1, value: SEXTET_PLUS};
        end else if (c == CH_SLASH) begin
            s = '{valid: 1'b1, value: SEXTET_SLASH};
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== src/b64ld_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b64ld_decode
    import b64ld_pkg::*;
(
    input  var t_state   i_state,
    input  var t_in_item i_item,
    output var t_state   o_next_state,
    output var t_bundle  o_bundle
);

    logic [7:0] ch;
    t_sextet    sx;
    logic [5:0] sx_val;
    logic       is_pad;
    t_state     upd;
    logic [1:0] pos_new;
    logic       stop_fin;
    logic       grp_emit;
    logic       tail_emit;
    logic       emit;
    logic       has1;
    logic       has2;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] bytes [MAX_RESULTS];
    logic [1:0] nb;
    logic [1:0] n;
    logic [1:0] last_idx;

    assign ch     = normalize_char(i_item.text_char);
    assign sx     = lookup_sextet(ch);
    assign sx_val = sx.valid ? sx.value : '0;
    assign is_pad = (ch == CH_PAD);

    // Place the character into the group.
    always_comb begin
        upd = i_state;
        case (i_state.group_position)
            2'd0: begin
                upd.first_sextet = sx_val;
                if (!sx.valid) begin
                    upd.stopped_flag = 1'b1;
                end
            end
            2'd1: begin
                upd.second_sextet = sx_val;
                if (!sx.valid) begin
                    upd.stopped_flag = 1'b1;
                end
            end
            2'd2: begin
                upd.third_sextet  = sx_val;
                upd.third_was_pad = is_pad;
            end
            default: begin
            end
        endcase
        upd.group_position = i_state.group_position + 2'd1;
    end

    assign pos_new = upd.group_position;

    // A one-character final group cannot be padded into a valid group.
    assign stop_fin  = upd.stopped_flag
                     | (i_item.message_last & (pos_new == 2'd1));
    assign grp_emit  = (i_state.group_position == 2'd3) & ~upd.stopped_flag;
    assign tail_emit = i_item.message_last & ~stop_fin
                     & ((pos_new == 2'd2) | (pos_new == 2'd3));
    assign emit      = grp_emit | tail_emit;

    always_comb begin
        has1 = 1'b0;
        has2 = 1'b0;
        if (grp_emit) begin
            has1 = ~upd.third_was_pad;
            has2 = ~is_pad;
        end else if (tail_emit) begin
            has1 = (pos_new == 2'd3) & ~upd.third_was_pad;
        end
    end

    assign b0 = {upd.first_sextet, upd.second_sextet[5:4]};
    assign b1 = {upd.second_sextet[3:0], upd.third_sextet[5:2]};
    assign b2 = {upd.third_sextet[1:0], sx_val};

    // Compact the emitted bytes so that a skipped second byte leaves no gap.
    assign bytes[0] = b0;
    assign bytes[1] = has1 ? b1 : b2;
    assign bytes[2] = b2;

    assign nb       = {1'b0, emit} + {1'b0, has1} + {1'b0, has2};
    assign n        = (i_item.message_last && nb == 2'd0) ? 2'd1 : nb;
    assign last_idx = n - 2'd1;

    always_comb begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            o_bundle.res[k].byte_present   = (2'(k) < nb);
            o_bundle.res[k].data_byte      = (2'(k) < nb) ? bytes[k] : '0;
            o_bundle.res[k].run_last       = (2'(k) == last_idx);
            o_bundle.res[k].message_end    = i_item.message_last & (2'(k) == last_idx);
            o_bundle.res[k].decode_stopped = stop_fin;
        end
        o_bundle.count = n;
    end

    // The message's final character returns everything to reset.
    always_comb begin
        if (i_item.message_last) begin
            o_next_state = '0;
        end else begin
            o_next_state = upd;
        end
    end

endmodule

`default_nettype wire

// ===== src/base64_lenient_decoder.sv =====
// Lenient URL-safe base64 decoder. Each input request carries one character and
// a flag on the message's last character; '-', '_' and '.' are read as '+', '/'
// and '='. Characters are grouped in fours; every complete group gives one to
// three bytes, a short final group is taken as padded, and an invalid first or
// second group character stops decoding until the message ends. Each result
// request carries one byte or, when a message ends without bytes, a bare end
// marker. A character is decoded in the cycle it is accepted and its results
// appear in the next cycle from a three-entry result register, one result per
// cycle while the receiver is ready. A character is accepted every cycle unless
// it produces results while that register still holds more than the one result
// leaving this cycle. Inside a message only the fourth character of a group
// produces results, and its three bytes drain while the next three characters
// (producing nothing) are accepted, so such a stream sustains one character per
// cycle whenever results are taken as fast as they appear. Near the end of a
// message the final character's results can follow closely on earlier ones, for
// example a message that ends one or two characters after a complete group, and
// then the input waits while the earlier results drain.
`timescale 1ns / 1ps
`default_nettype none

module base64_lenient_decoder
    import b64ld_pkg::*;
(
    input  var logic      i_clk,
    input  var logic      i_rst_n,
    input  var logic      i_in_valid,
    output var logic      o_in_ready,
    input  var t_in_item  i_in_data,
    output var logic      o_out_valid,
    input  var logic      i_out_ready,
    output var t_out_item o_out_data
);

    t_state    r_state;
    t_state    n_state;
    t_bundle   bnd;
    t_out_item r_slot [MAX_RESULTS];
    logic [1:0] r_cnt;
    logic       in_acc;
    logic       out_pop;
    logic       load;

    // Combinational step: group bookkeeping and byte assembly for one character.
    b64ld_decode u_decode (
        .i_state      (r_state),
        .i_item       (i_in_data),
        .o_next_state (n_state),
        .o_bundle     (bnd)
    );

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_slot[0];
    assign out_pop     = o_out_valid & i_out_ready;

    // A character that yields nothing never waits for the result register.
    assign o_in_ready = (bnd.count == 2'd0)
                      | (r_cnt == 2'd0)
                      | ((r_cnt == 2'd1) & i_out_ready);
    assign in_acc     = i_in_valid & o_in_ready;
    assign load       = in_acc & (bnd.count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_cnt   <= '0;
        end else begin
            if (in_acc) begin
                r_state <= n_state;
            end
            if (load) begin
                r_cnt <= bnd.count;
            end else if (out_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Result entries shift toward entry 0 as each one is taken.
    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                r_slot[k] <= bnd.res[k];
            end
        end else if (out_pop) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                r_slot[k] <= r_slot[k+1];
            end
        end
    end

    // A new set of results never overwrites one still being delivered.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready))
        else $error("result register overwritten while holding results");

    // The message's last character leaves the decoder at the start of a group.
    a_msg_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.message_last |=>
            (r_state.group_position == 2'd0) && !r_state.stopped_flag)
        else $error("decoder state not cleared after message end");

    // A result that does not close its run must have a follower in the register.
    a_run_follow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.run_last |-> (r_cnt == 2'd2) || (r_cnt == 2'd3))
        else $error("run not closed before result register empties");

    // Once stopped, a character never produces a byte.
    a_stop_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_state.stopped_flag |-> !bnd.res[0].byte_present)
        else $error("byte produced after decoding stopped");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import b64ld_pkg::*;

    // Clock, reset and the two request channels of the decoder.
    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    base64_lenient_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Characters still to be offered, and the results that the decoder owes us.
    t_in_item   pending_chars[$];
    t_out_item  expected_results[$];
    logic [7:0] msg_chars[$];

    // Our own copy of the decoder state, advanced once per accepted character.
    t_state dec_state = '0;

    int  chars_total = 0;
    int  chars_accepted = 0;
    int  messages_sent = 0;
    int  bytes_seen = 0;
    int  bare_markers = 0;
    int  stopped_messages = 0;
    int  error_count = 0;
    bit  in_fire = 1'b0;
    int  hold_left = 0;
    int  holds_done = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // The run is cut off well after the slowest legal run would have ended.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Idle percentages move through three phases as the run progresses: first the
    // sender rarely idles and the receiver often does, then the reverse, and at the
    // end neither side idles at all.
    function automatic int idle_pct(input bit for_sender);
        if (chars_accepted < chars_total / 3) begin
            return for_sender ? 11 : 72;
        end else if (chars_accepted < (2 * chars_total) / 3) begin
            return for_sender ? 72 : 11;
        end
        return 0;
    endfunction

    // Predicts the results of one character. The character is folded onto the
    // standard alphabet, placed in its group, and bytes come out on the fourth
    // character or when the message ends on a short group.
    task automatic decode_char(input t_in_item item);
        logic [7:0] ch;
        logic [7:0] tmp;
        logic [5:0] sx;
        logic       is_valid;
        logic       is_pad;
        logic [7:0] bytes [3];
        int         nb;
        int         n;
        t_out_item  r;

        ch = item.text_char;
        case (ch)
            CH_DASH:  ch = CH_PLUS;
            CH_UNDER: ch = CH_SLASH;
            CH_DOT:   ch = CH_PAD;
            default:  ch = ch;
        endcase

        is_valid = 1'b1;
        tmp = 8'd0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            tmp = ch - CH_UPPER_A;
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            tmp = ch - CH_LOWER_A + LOWER_BASE;
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            tmp = ch - CH_DIGIT_0 + DIGIT_BASE;
        end else if (ch == CH_PLUS) begin
            tmp = {2'b00, SEXTET_PLUS};
        end else if (ch == CH_SLASH) begin
            tmp = {2'b00, SEXTET_SLASH};
        end else begin
            is_valid = 1'b0;
        end
        // An invalid character always contributes a zero sextet.
        sx = tmp[5:0];
        is_pad = (ch == CH_PAD);
        nb = 0;

        case (dec_state.group_position)
            2'd0: begin
                if (!is_valid) begin
                    dec_state.stopped_flag = 1'b1;
                end
                dec_state.first_sextet = sx;
            end
            2'd1: begin
                if (!is_valid) begin
                    dec_state.stopped_flag = 1'b1;
                end
                dec_state.second_sextet = sx;
            end
            2'd2: begin
                dec_state.third_sextet = sx;
                dec_state.third_was_pad = is_pad;
            end
            default: begin
                if (!dec_state.stopped_flag) begin
                    bytes[nb] = {dec_state.first_sextet, dec_state.second_sextet[5:4]};
                    nb = nb + 1;
                    if (!dec_state.third_was_pad) begin
                        bytes[nb] = {dec_state.second_sextet[3:0],
                                     dec_state.third_sextet[5:2]};
                        nb = nb + 1;
                    end
                    if (!is_pad) begin
                        bytes[nb] = {dec_state.third_sextet[1:0], sx};
                        nb = nb + 1;
                    end
                end
            end
        endcase
        dec_state.group_position = dec_state.group_position + 2'd1;

        // A message that ends inside a group is read as padded with '='. A lone
        // character cannot form a byte, so it stops decoding instead.
        if (item.message_last && dec_state.group_position != 2'd0) begin
            if (dec_state.group_position == 2'd1) begin
                dec_state.stopped_flag = 1'b1;
            end else if (!dec_state.stopped_flag) begin
                bytes[nb] = {dec_state.first_sextet, dec_state.second_sextet[5:4]};
                nb = nb + 1;
                if (dec_state.group_position == 2'd3 && !dec_state.third_was_pad) begin
                    bytes[nb] = {dec_state.second_sextet[3:0], dec_state.third_sextet[5:2]};
                    nb = nb + 1;
                end
            end
        end

        // The last character always yields something, a bare end marker at least.
        n = (item.message_last && nb == 0) ? 1 : nb;
        for (int k = 0; k < n; k++) begin
            r.byte_present   = (k < nb);
            r.data_byte      = (k < nb) ? bytes[k] : 8'd0;
            r.run_last       = (k == n - 1);
            r.message_end    = item.message_last && (k == n - 1);
            r.decode_stopped = dec_state.stopped_flag;
            expected_results = {expected_results, r};
        end

        if (item.message_last) begin
            dec_state = '0;
        end
    endtask

    // Message building: characters collect in msg_chars and are then queued as
    // requests, with the last one flagged.
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            msg_chars = {msg_chars, s[i]};
        end
    endtask

    task automatic add_char(input logic [7:0] c);
        msg_chars = {msg_chars, c};
    endtask

    task automatic end_message();
        t_in_item item;
        for (int i = 0; i < msg_chars.size(); i++) begin
            item.text_char    = msg_chars[i];
            item.message_last = (i == msg_chars.size() - 1);
            pending_chars = {pending_chars, item};
        end
        msg_chars.delete();
        messages_sent++;
    endtask

    // A random character of the alphabet, using the URL-safe spelling half the time for the two that have one.
    function automatic logic [7:0] alphabet_char();
        int k;
        k = $urandom_range(0, 63);
        if (k < 26) begin
            return CH_UPPER_A + 8'(k);
        end else if (k < 52) begin
            return CH_LOWER_A + 8'(k - 26);
        end else if (k < 62) begin
            return CH_DIGIT_0 + 8'(k - 52);
        end else if (k == 62) begin
            return $urandom_range(0, 1) ? CH_PLUS : CH_DASH;
        end
        return $urandom_range(0, 1) ? CH_SLASH : CH_UNDER;
    endfunction

    function automatic logic [7:0] pad_char();
        return $urandom_range(0, 1) ? CH_PAD : CH_DOT;
    endfunction

    // Stimulus and end of run.
    initial begin
        int groups;
        int tail;
        int kind;
        int len;

        // Directed part. A full group of high sextets partly in URL-safe spelling, pads
        // in the third and fourth places, invalid third and fourth characters, an invalid
        // first character, an invalid second character, and short final groups of
        // one, two and three characters.
        add_text("//-_");
        end_message();
        add_text("AA..");
        end_message();
        add_text("QQ=A");
        end_message();
        add_text("QU*");
        add_char(8'h00);
        end_message();
        add_char(8'hFF);
        add_text("A");
        end_message();
        add_text("A");
        add_char(8'h80);
        add_text("Q");
        end_message();
        add_text("Q");
        end_message();
        add_text("QQ");
        end_message();
        add_text("QUE");
        end_message();

        // Random part. Most messages are well formed with random content, some have
        // one character broken, and a few are raw byte noise.
        while (pending_chars.size() < 460) begin
            kind = $urandom_range(0, 9);
            if (kind < 9) begin
                groups = $urandom_range(0, 3);
                tail = $urandom_range(0, 3);
                if (groups == 0 && tail == 0) begin
                    tail = 2;
                end
                for (int i = 0; i < 4 * groups + tail; i++) begin
                    add_char(alphabet_char());
                end
                if (tail == 2 && $urandom_range(0, 1)) begin
                    add_char(pad_char());
                    add_char(pad_char());
                end else if (tail == 3 && $urandom_range(0, 1)) begin
                    add_char(pad_char());
                end
                if (kind >= 7) begin
                    msg_chars[$urandom_range(0, msg_chars.size() - 1)] =
                        8'($urandom_range(0, 255));
                end
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    add_char(8'($urandom_range(0, 255)));
                end
            end
            end_message();
        end
        chars_total = pending_chars.size();

        // Reset is held low at the start and released on a falling edge.
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (chars_accepted < chars_total || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        // The run goes on past that point so that a stray late result would still be caught.
        repeat (16) @(posedge i_clk);

        $display("Sent %0d characters in %0d messages; received %0d bytes and %0d bare end markers.",
                 chars_total, messages_sent, bytes_seen, bare_markers);
        $display("%0d messages ended with decoding stopped; %0d receiver hold-offs applied.",
                 stopped_messages, holds_done);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Sender: a new request is offered on the falling edge only once the held one
    // has been taken, so valid and the payload stay put until acceptance.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (pending_chars.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_chars.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls per phase, plus two long hold-offs while the sender
    // keeps offering, which fills the result register and stalls the input side.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && chars_accepted >= (holds_done == 0 ? 60 : 250)) begin
            i_out_ready <= 1'b0;
            hold_left <= 80;
            holds_done <= holds_done + 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
        end
    end

    // Monitor: both channels are sampled on the rising edge. Results are checked
    // before the same edge's input is predicted, since a result can never belong
    // to a character accepted on the same edge.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result: byte %02h present %b run_last %b end %b stopped %b",
                             $time, o_out_data.data_byte, o_out_data.byte_present,
                             o_out_data.run_last, o_out_data.message_end,
                             o_out_data.decode_stopped);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.data_byte !== want.data_byte
                            || o_out_data.byte_present !== want.byte_present
                            || o_out_data.run_last !== want.run_last
                            || o_out_data.message_end !== want.message_end
                            || o_out_data.decode_stopped !== want.decode_stopped) begin
                        error_count++;
                        $display("%0t: mismatch: expected byte %02h present %b run_last %b end %b stopped %b",
                                 $time, want.data_byte, want.byte_present, want.run_last,
                                 want.message_end, want.decode_stopped);
                        $display("%0t:           actual byte %02h present %b run_last %b end %b stopped %b",
                                 $time, o_out_data.data_byte, o_out_data.byte_present,
                                 o_out_data.run_last, o_out_data.message_end,
                                 o_out_data.decode_stopped);
                    end
                    if (want.byte_present) begin
                        bytes_seen++;
                    end else begin
                        bare_markers++;
                    end
                    if (want.message_end && want.decode_stopped) begin
                        stopped_messages++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                decode_char(i_in_data);
                chars_accepted <= chars_accepted + 1;
            end
        end
    end

endmodule

// ===== filelist.f =====
src/b64ld_pkg.sv
src/b64ld_decode.sv
src/base64_lenient_decoder.sv
sim/tb_top.sv
